// ===== sv/nir_pkg.sv =====
`timescale 1ns / 1ps

package nir_pkg;

	// Fixed field and store widths
	localparam int CNT_W      = 9;
	localparam int TIME_W     = 32;
	localparam int ADDR_W     = 16;
	localparam int CMD_W      = 8;
	localparam int STATUS_W   = 2;
	localparam int MINP_W     = 9;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// Frame layout: 32 data bits on every second pulse from pulse 4
	localparam int FIRST_DATA_PULSE = 4;
	localparam int DATA_BITS        = 32;
	localparam int MIN_FRAME_FLOOR  = 67;
	localparam int REPEAT_LO        = 3;
	localparam int REPEAT_HI        = 5;

	// Register reset values
	localparam logic [ADDR_W-1:0] RST_REMOTE_ADDRESS = '0;
	localparam logic [TIME_W-1:0] RST_IDLE_TIMEOUT   = 32'd20000;
	localparam logic [TIME_W-1:0] RST_BIT_THRESHOLD  = 32'd1500;
	localparam logic [MINP_W-1:0] RST_MIN_FRAME      = 9'd67;

	// Register indexes (word address)
	localparam logic [1:0] REG_REMOTE_ADDRESS = 2'd0;
	localparam logic [1:0] REG_IDLE_TIMEOUT   = 2'd1;
	localparam logic [1:0] REG_BIT_THRESHOLD  = 2'd2;
	localparam logic [1:0] REG_MIN_FRAME      = 2'd3;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_NONE   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_VALID  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REPEAT = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] remote_address;
		logic [TIME_W-1:0] idle_timeout;
		logic [TIME_W-1:0] bit_threshold;
		logic [MINP_W-1:0] min_frame_pulses;
	} nir_cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;     // latch the polled level and time
		logic edge_upd;    // apply a level change, store one pulse bit
		logic clr_count;   // frame ended, drop pulse count
		logic rd_start;    // point the read index at the first data pulse
		logic rd_issue;    // read one stored pulse, step the index
		logic res_zero;    // result: no data
		logic res_repeat;  // result: repeat
		logic res_check;   // result: from decoded frame bits
	} nir_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic timeout;
		logic full_frame;
		logic repeat_cnt;
	} nir_stat_t;

endpackage

// ===== sv/nir_ram.sv =====
`timescale 1ns / 1ps

module nir_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/nir_datapath.sv =====
`timescale 1ns / 1ps

module nir_datapath import nir_pkg::*; #(
	parameter int PULSE_DEPTH = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  nir_cfg_t            cfg,
	input  nir_cmd_t            cmd,
	input  logic                pin_level,
	input  logic [TIME_W-1:0]   timer_value,
	output nir_stat_t           stat,
	output logic [STATUS_W-1:0] status,
	output logic [CMD_W-1:0]    command_byte
);

	localparam int AW = $clog2(PULSE_DEPTH);

	logic                level_q;
	logic [TIME_W-1:0]   now_q;
	logic                last_level_q;
	logic [TIME_W-1:0]   last_edge_q;
	logic [CNT_W-1:0]    count_q;
	logic [AW-1:0]       rd_idx_q;
	logic                rd_valid_q;
	logic [DATA_BITS-1:0] bits_q;
	logic [STATUS_W-1:0] status_q;
	logic [CMD_W-1:0]    command_q;

	logic                level_change;
	logic                store_room;
	logic                pulse_long;
	logic                ram_we;
	logic                ram_rdata;
	logic [TIME_W-1:0]   pulse_dur;
	logic [TIME_W-1:0]   idle_dur;
	logic [MINP_W-1:0]   min_pulses;
	logic [ADDR_W-1:0]   frm_addr;
	logic [CMD_W-1:0]    frm_cmd;
	logic [CMD_W-1:0]    frm_inv;
	logic                frm_ok;

	// Edge detect and pulse classification (time wraps modulo 2^32)
	assign level_change = level_q != last_level_q;
	assign pulse_dur    = now_q - last_edge_q;
	assign pulse_long   = pulse_dur > cfg.bit_threshold;
	assign store_room   = count_q < CNT_W'(PULSE_DEPTH);
	assign ram_we       = cmd.edge_upd & level_change & store_room;

	// Frame end: idle high long enough with pulses held
	assign idle_dur   = now_q - last_edge_q;
	assign min_pulses = (cfg.min_frame_pulses < MINP_W'(MIN_FRAME_FLOOR)) ?
		MINP_W'(MIN_FRAME_FLOOR) : cfg.min_frame_pulses;

	assign stat.timeout    = level_q & (count_q != '0) & (idle_dur > cfg.idle_timeout);
	assign stat.full_frame = count_q >= min_pulses;
	assign stat.repeat_cnt = (count_q >= CNT_W'(REPEAT_LO)) & (count_q <= CNT_W'(REPEAT_HI));

	// Decoded frame fields, MSB first
	assign frm_addr = bits_q[DATA_BITS-1 -: ADDR_W];
	assign frm_cmd  = bits_q[2*CMD_W-1 -: CMD_W];
	assign frm_inv  = bits_q[CMD_W-1:0];
	assign frm_ok   = (frm_addr == cfg.remote_address) & (frm_cmd == ~frm_inv);

	nir_ram #(
		.WIDTH (1),
		.DEPTH (PULSE_DEPTH)
	) u_pulse_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (pulse_long),
		.re    (cmd.rd_issue),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	// Control registers: edge tracking, pulse count, read valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b1;
			last_edge_q  <= '0;
			count_q      <= '0;
			rd_valid_q   <= 1'b0;
		end else begin
			rd_valid_q <= cmd.rd_issue;
			if (cmd.edge_upd && level_change) begin
				last_level_q <= level_q;
				last_edge_q  <= now_q;
				if (store_room) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.clr_count) begin
				count_q <= '0;
			end
		end
	end

	// Payload: poll capture, read index, frame bits, result
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			level_q <= pin_level;
			now_q   <= timer_value;
		end
		if (cmd.rd_start) begin
			rd_idx_q <= AW'(FIRST_DATA_PULSE);
		end else if (cmd.rd_issue) begin
			rd_idx_q <= rd_idx_q + AW'(2);
		end
		if (rd_valid_q) begin
			bits_q <= {bits_q[DATA_BITS-2:0], ram_rdata};
		end
		if (cmd.res_zero) begin
			status_q  <= ST_NONE;
			command_q <= '0;
		end else if (cmd.res_repeat) begin
			status_q  <= ST_REPEAT;
			command_q <= '0;
		end else if (cmd.res_check) begin
			status_q  <= frm_ok ? ST_VALID : ST_NONE;
			command_q <= frm_ok ? frm_cmd : '0;
		end
	end

	assign status       = status_q;
	assign command_byte = command_q;

endmodule

// ===== sv/nir_ctrl.sv =====
`timescale 1ns / 1ps

module nir_ctrl import nir_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  nir_stat_t stat,
	output nir_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	localparam int RC_W = $clog2(DATA_BITS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EDGE,
		S_CHECK,
		S_READ,
		S_DRAIN,
		S_DECIDE
	} state_t;

	state_t         state_q;
	logic [RC_W-1:0] rd_cnt_q;
	logic           done_q;

	// Commands decoded from the current state
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.capture = start;
			end
			S_EDGE: begin
				cmd.edge_upd = 1'b1;
			end
			S_CHECK: begin
				cmd.clr_count = stat.timeout;
				if (stat.timeout && stat.full_frame) begin
					cmd.rd_start = 1'b1;
				end else if (stat.timeout && stat.repeat_cnt) begin
					cmd.res_repeat = 1'b1;
				end else begin
					cmd.res_zero = 1'b1;
				end
			end
			S_READ: begin
				cmd.rd_issue = 1'b1;
			end
			S_DRAIN: begin
			end
			S_DECIDE: begin
				cmd.res_check = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// State, read counter and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rd_cnt_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EDGE;
					end
				end
				S_EDGE: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (stat.timeout && stat.full_frame) begin
						rd_cnt_q <= '0;
						state_q  <= S_READ;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == RC_W'(DATA_BITS - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

endmodule

// ===== sv/nec_ir_frame_decoder.sv =====
// NEC infrared remote frame decoder.
//
// Requests: drive pin_level and timer_value (one pin poll) and pulse start;
// a request is taken at a clock edge with start high and busy low.
// Every request gives exactly one result: status and command_byte are valid
// for the single cycle in which done is high. The receiver cannot hold a
// result off, and none is needed: one request is in flight at a time.
// Sequence: a plain poll steps through the edge and check states, and done
// rises from check; when a poll ends a full-length frame the 32 data pulses
// are read one per cycle from the pulse RAM, then drain and decide precede
// done. busy falls in the cycle done is high, so a new request may be taken there.
// Configuration: APB, four 32-bit registers at 0x0 remote address,
// 0x4 idle timeout, 0x8 bit threshold, 0xC minimum frame pulse count.
// Write only while busy is low and no result is pending.
// Reset: pulse count zero, last level high, last edge time zero, registers
// to their defaults. The pulse RAM is not cleared.
`timescale 1ns / 1ps

module nec_ir_frame_decoder import nir_pkg::*; #(
	parameter int PULSE_DEPTH = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  pin_level,
	input  logic [TIME_W-1:0]     timer_value,
	output logic                  done,
	output logic [STATUS_W-1:0]   status,
	output logic [CMD_W-1:0]      command_byte,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	nir_cfg_t  cfg_q;
	nir_cmd_t  cmd;
	nir_stat_t stat;
	logic      cfg_wr;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.remote_address   <= RST_REMOTE_ADDRESS;
			cfg_q.idle_timeout     <= RST_IDLE_TIMEOUT;
			cfg_q.bit_threshold    <= RST_BIT_THRESHOLD;
			cfg_q.min_frame_pulses <= RST_MIN_FRAME;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_REMOTE_ADDRESS: cfg_q.remote_address   <= pwdata[ADDR_W-1:0];
				REG_IDLE_TIMEOUT:   cfg_q.idle_timeout     <= pwdata[TIME_W-1:0];
				REG_BIT_THRESHOLD:  cfg_q.bit_threshold    <= pwdata[TIME_W-1:0];
				REG_MIN_FRAME:      cfg_q.min_frame_pulses <= pwdata[MINP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (reg_idx)
			REG_REMOTE_ADDRESS: prdata = APB_DATA_W'(cfg_q.remote_address);
			REG_IDLE_TIMEOUT:   prdata = APB_DATA_W'(cfg_q.idle_timeout);
			REG_BIT_THRESHOLD:  prdata = APB_DATA_W'(cfg_q.bit_threshold);
			REG_MIN_FRAME:      prdata = APB_DATA_W'(cfg_q.min_frame_pulses);
			default:            prdata = '0;
		endcase
	end

	nir_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	nir_datapath #(
		.PULSE_DEPTH (PULSE_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.pin_level    (pin_level),
		.timer_value  (timer_value),
		.stat         (stat),
		.status       (status),
		.command_byte (command_byte)
	);

endmodule
